// ===== design/udec_pkg.sv =====
package udec_pkg;

  // Width of one decoded unit (code point or UTF-16 unit).
  localparam int unsigned UnitW = 21;

  // Replacement character and code space limits.
  localparam logic [UnitW-1:0] ReplChar    = 21'h00FFFD;
  localparam logic [UnitW-1:0] SurrLow     = 21'h00D800;
  localparam logic [UnitW-1:0] SurrHigh    = 21'h00DFFF;
  localparam logic [UnitW-1:0] PlaneOne    = 21'h010000;
  localparam logic [UnitW-1:0] TwoByteMin  = 21'h000080;
  localparam logic [UnitW-1:0] ThreeByteMin = 21'h000800;
  localparam logic [UnitW-1:0] MaxPoint    = 21'h10FFFF;
  localparam logic [UnitW-1:0] HiSurrBase  = 21'h00D800;
  localparam logic [UnitW-1:0] LoSurrBase  = 21'h00DC00;

  // One input item: a raw byte and the end-of-text mark.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_text;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [UnitW-1:0] unit_value;
    logic             invalid;
    logic             run_last;
  } out_item_t;

  // One decoded unit before it is tagged with its position in the run.
  typedef struct packed {
    logic [UnitW-1:0] value;
    logic             invalid;
  } unit_t;

  // All results of one input byte: zero, one or two units.
  typedef struct packed {
    logic [1:0] cnt;
    unit_t      first;
    unit_t      second;
  } job_t;

endpackage

// ===== design/udec_front.sv =====
module udec_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            accept_i,
  input  udec_pkg::in_item_t item_i,
  output udec_pkg::job_t  job_o
);
  import udec_pkg::*;

  logic             form_q;
  logic [UnitW-1:0] pp_q, pp_d;
  logic [1:0]       exp_q, exp_d;
  logic [1:0]       seq_q, seq_d;
  logic             skip_q, skip_d;

  logic [UnitW-1:0] acc;
  logic             cont;
  logic             bad;
  logic [7:0]       b;
  job_t             j;

  // Appends one unit to the byte's results; a third unit is dropped.
  function automatic job_t add_unit(job_t jin, unit_t u);
    job_t jo;
    jo = jin;
    if (jin.cnt == 2'd0) begin
      jo.first = u;
      jo.cnt   = 2'd1;
    end else if (jin.cnt == 2'd1) begin
      jo.second = u;
      jo.cnt    = 2'd2;
    end
    return jo;
  endfunction

  // Appends a code point, as a surrogate pair in UTF-16 form if above the BMP.
  function automatic job_t add_point(job_t jin, logic [UnitW-1:0] p, logic utf16);
    job_t             jo;
    logic [UnitW-1:0] q;
    unit_t            hi;
    unit_t            lo;
    jo = jin;
    q  = p - PlaneOne;
    hi.value   = HiSurrBase + {11'b0, q[19:10]};
    hi.invalid = 1'b0;
    lo.value   = LoSurrBase + {11'b0, q[9:0]};
    lo.invalid = 1'b0;
    if (utf16 && (p >= PlaneOne)) begin
      jo = add_unit(jo, hi);
      jo = add_unit(jo, lo);
    end else begin
      jo = add_unit(jo, '{value: p, invalid: 1'b0});
    end
    return jo;
  endfunction

  localparam unit_t Repl = '{value: ReplChar, invalid: 1'b1};

  // Classify the byte, update the sequence state and build its results.
  always_comb begin
    b      = item_i.byte_value;
    cont   = (b[7:6] == 2'b10);
    j      = '0;
    pp_d   = pp_q;
    exp_d  = exp_q;
    seq_d  = seq_q;
    skip_d = skip_q;
    acc    = {pp_q[UnitW-7:0], b[5:0]};
    bad    = 1'b0;
    if ((exp_q != 2'd0) && cont) begin
      pp_d  = acc;
      exp_d = exp_q - 2'd1;
      if (exp_d == 2'd0) begin
        bad = ((acc >= SurrLow) && (acc <= SurrHigh)) || (acc < TwoByteMin) ||
              ((seq_q > 2'd1) && (acc < ThreeByteMin)) ||
              ((seq_q > 2'd2) && (acc < PlaneOne)) || (acc > MaxPoint);
        if (bad) begin
          j = add_unit(j, Repl);
        end else begin
          j = add_point(j, acc, form_q);
        end
      end
    end else begin
      // A sequence cut short is replaced, then the byte starts afresh.
      if (exp_q != 2'd0) begin
        j     = add_unit(j, Repl);
        exp_d = 2'd0;
      end
      if (!(skip_q && cont)) begin
        skip_d = 1'b0;
        if (!b[7]) begin
          j = add_point(j, {13'b0, b}, form_q);
        end else if (cont) begin
          j      = add_unit(j, Repl);
          skip_d = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          pp_d  = {16'b0, b[4:0]};
          exp_d = 2'd1;
          seq_d = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          pp_d  = {17'b0, b[3:0]};
          exp_d = 2'd2;
          seq_d = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          pp_d  = {18'b0, b[2:0]};
          exp_d = 2'd3;
          seq_d = 2'd3;
        end else begin
          j      = add_unit(j, Repl);
          skip_d = 1'b1;
        end
      end
    end
    // End of text closes any open sequence and clears all state.
    if (item_i.end_of_text) begin
      if (exp_d != 2'd0) begin
        j = add_unit(j, Repl);
      end
      exp_d  = 2'd0;
      seq_d  = 2'd0;
      pp_d   = '0;
      skip_d = 1'b0;
    end
  end

  assign job_o = j;

  // Decoder state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      exp_q  <= 2'd0;
      seq_q  <= 2'd0;
      skip_q <= 1'b0;
    end else if (accept_i) begin
      pp_q   <= pp_d;
      exp_q  <= exp_d;
      seq_q  <= seq_d;
      skip_q <= skip_d;
    end
  end

  // Output form register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q <= 1'b0;
    end else if (cfg_we_i) begin
      form_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== design/udec_queue.sv =====
module udec_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  udec_pkg::job_t data_i,
  input  logic           pop_i,
  output udec_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import udec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/udec_back.sv =====
module udec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  udec_pkg::job_t     job_i,
  input  logic               avail_i,
  input  logic               pop_i,
  output logic               deq_o,
  output udec_pkg::out_item_t item_o
);
  import udec_pkg::*;

  // Which unit of the head job is on the output.
  logic  slot_q;
  logic  last;
  unit_t cur;

  assign cur  = slot_q ? job_i.second : job_i.first;
  assign last = slot_q || (job_i.cnt == 2'd1);

  assign item_o.unit_value = cur.value;
  assign item_o.invalid    = cur.invalid;
  assign item_o.run_last   = last;

  // The head job leaves the queue once its last unit is taken.
  assign deq_o = pop_i && avail_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 1'b0;
    end else if (pop_i && avail_i) begin
      slot_q <= !last;
    end
  end

endmodule

// ===== design/utf8_validating_decoder.sv =====
// Channel   | Ports                          | Accepted when
// ----------+--------------------------------+-------------------------
// bytes in  | push, full, in_item_i          | push && !full
// results   | empty, pop, out_item_o         | pop && !empty
// config    | cfg_we_i, cfg_wdata_i          | cfg_we_i
//
// One byte is decoded and accepted per cycle while the job queue has room.
// A byte that yields two units holds the result side for two pops, so the
// sustained rate with pop held is one result per cycle, set by the single port.
// Bytes that yield no result still take a queue check but occupy no entry.
// Reset clears the decoder state, the output form and the queue at once.
module utf8_validating_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  udec_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output udec_pkg::out_item_t out_item_o
);
  import udec_pkg::*;

  job_t new_job, head_job;
  logic accept, enq, deq, q_full, q_empty;

  assign full   = q_full;
  assign empty  = q_empty;
  assign accept = push && !q_full;
  assign enq    = accept && (new_job.cnt != 2'd0);

  // Front: byte classification and sequence state.
  udec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_o       (new_job)
  );

  // Queue of per-byte result jobs.
  udec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (new_job),
    .pop_i   (deq),
    .data_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: hands out the units of each job one at a time.
  udec_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .avail_i (!q_empty),
    .pop_i   (pop),
    .deq_o   (deq),
    .item_o  (out_item_o)
  );

endmodule
